/* src/weight_prune_splice_mask_defines.svh */
// assertion macros for the pruning mask unit
`ifndef WEIGHT_PRUNE_SPLICE_MASK_DEFINES_SVH
`define WEIGHT_PRUNE_SPLICE_MASK_DEFINES_SVH

// checked only outside reset
`define WPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define WPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/wps_pkg.sv */
// ----------------------------------------------------------------------------
// wps_pkg
// Types and constants shared by the pruning mask unit.
// ----------------------------------------------------------------------------
package wps_pkg;

  localparam int unsigned WEIGHT_BITS = 16;
  localparam int unsigned MAG_BITS    = WEIGHT_BITS - 1;
  localparam int unsigned ABS_W       = 36;
  localparam int unsigned SQ_W        = 50;
  localparam int unsigned CNT_W       = 21;
  localparam int unsigned RATIO_W     = 16;
  localparam int unsigned PROD_W      = 32;
  localparam int unsigned MAX_WEIGHTS = 1048576;
  localparam int unsigned DIV_STEPS   = SQ_W;
  localparam int unsigned SQRT_STEPS  = SQ_W / 2;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd4096;

  localparam logic [1:0] OP_ACCUM    = 2'd0;
  localparam logic [1:0] OP_FINALIZE = 2'd1;
  localparam logic [1:0] OP_CLASSIFY = 2'd2;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  typedef enum logic [1:0] {
    K_ACCUM,
    K_FINAL,
    K_CLASS
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MEAN,
    ST_VAR,
    ST_SQRT,
    ST_DONE,
    ST_PREP
  } state_e;

  typedef struct packed {
    logic [1:0]                    opcode;
    logic signed [WEIGHT_BITS-1:0] weight_value;
    logic                          mask_in;
  } in_t;

  typedef struct packed {
    logic                          result_kind;
    logic                          new_mask;
    logic signed [WEIGHT_BITS-1:0] masked_weight;
    logic [MAG_BITS-1:0]           mean_abs_out;
    logic [MAG_BITS-1:0]           std_dev_out;
  } out_t;

  typedef struct packed {
    kind_e                  kind;
    logic [WEIGHT_BITS-1:0] wraw;
    logic [WEIGHT_BITS-1:0] mag;
    logic                   mask;
  } entry_t;

endpackage

/* src/wps_front.sv */
// ----------------------------------------------------------------------------
// wps_front
// Accepts input transactions, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module wps_front import wps_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  in_t    in_data_i,
  output logic   head_valid_o,
  output entry_t head_o,
  input  logic   pop_i
);

  entry_t      mem_q [2];
  logic        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  entry_t      ent;
  logic        push, pop;

  always_comb begin
    ent.wraw = in_data_i.weight_value;
    ent.mask = in_data_i.mask_in;
    ent.mag  = in_data_i.weight_value[WEIGHT_BITS-1] ? (~ent.wraw + 1'b1) : ent.wraw;
    case (in_data_i.opcode)
      OP_ACCUM:    ent.kind = K_ACCUM;
      OP_FINALIZE: ent.kind = K_FINAL;
      default:     ent.kind = K_CLASS;
    endcase
  end

  assign in_ready_o   = (count_q != 2'd2);
  // unused opcode is taken and dropped
  assign push         = in_valid_i && in_ready_o && (in_data_i.opcode != OP_UNUSED);
  assign head_valid_o = (count_q != 2'd0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= ent;
    end
  end

endmodule

/* src/wps_back.sv */
// ----------------------------------------------------------------------------
// wps_back
// Executes queued items: accumulation, finalize (divide, square root) and
// threshold classification, with a registered result slot.
// ----------------------------------------------------------------------------
module wps_back import wps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RATIO_W-1:0] cfg_data_i,
  input  logic               head_valid_i,
  input  entry_t             head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o
);

  localparam logic [MAG_BITS-1:0] MAG_MAX = '1;

  state_e               state_q, state_d;
  logic [RATIO_W-1:0]   ratio_q;
  logic [ABS_W-1:0]     abs_q;
  logic [SQ_W-1:0]      sq_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [MAG_BITS-1:0]  mean_q, std_q, m_q;
  logic [PROD_W-1:0]    p_q;
  logic [SQ_W-1:0]      qa_q, qs_q, rad_q;
  logic [CNT_W-1:0]     ra_q, rs_q;
  logic [5:0]           step_q;
  logic [27:0]          srem_q;
  logic [25:0]          sroot_q;
  out_t                 out_q;
  logic                 out_valid_q;

  logic                 out_free, take, load_out;
  logic                 acc_en;
  logic [ABS_W:0]       abs_sum;
  logic [SQ_W:0]        sq_sum;
  logic [PROD_W-1:0]    mag_sq, lhs;
  logic [PROD_W+3:0]    p9, p11;
  logic                 nm;
  logic [CNT_W:0]       ta, ts;
  logic                 ga, gs;
  logic [27:0]          st, trial;
  logic                 gq;
  logic [2*MAG_BITS-1:0] msq;
  out_t                 cls_out, stat_out;
  logic [MAG_BITS-1:0]  std_sat;

  assign out_free = !out_valid_q || out_ready_i;
  assign take     = head_valid_i && (state_q == ST_IDLE) &&
                    ((head_i.kind != K_CLASS) || out_free);
  assign pop_o    = take;

  // accumulate datapath
  assign acc_en  = take && (head_i.kind == K_ACCUM) && head_i.mask &&
                   (head_i.mag != '0) && (cnt_q < CNT_W'(MAX_WEIGHTS));
  assign mag_sq  = PROD_W'(head_i.mag) * PROD_W'(head_i.mag);
  assign abs_sum = {1'b0, abs_q} + (ABS_W+1)'(head_i.mag);
  assign sq_sum  = {1'b0, sq_q} + (SQ_W+1)'(mag_sq);

  // classify: 40960*|w| against 9p and 11p
  assign lhs = {1'b0, head_i.mag, 15'b0} + {3'b0, head_i.mag, 13'b0};
  assign p9  = {p_q, 3'b0} + (PROD_W+4)'(p_q);
  assign p11 = {p_q, 3'b0} + (PROD_W+4)'({p_q, 1'b0}) + (PROD_W+4)'(p_q);
  assign nm  = head_i.mask ? !((PROD_W+4)'(lhs) <= p9) : ((PROD_W+4)'(lhs) > p11);

  always_comb begin
    cls_out.result_kind   = 1'b0;
    cls_out.new_mask      = nm;
    cls_out.masked_weight = nm ? head_i.wraw : '0;
    cls_out.mean_abs_out  = mean_q;
    cls_out.std_dev_out   = std_q;
  end

  // restoring division, one quotient bit per cycle on both sums
  assign ta = {ra_q, qa_q[SQ_W-1]};
  assign ts = {rs_q, qs_q[SQ_W-1]};
  assign ga = ta >= {1'b0, cnt_q};
  assign gs = ts >= {1'b0, cnt_q};

  // digit-by-digit square root, two radicand bits per cycle
  assign st    = {srem_q[25:0], rad_q[SQ_W-1 -: 2]};
  assign trial = {sroot_q, 2'b01};
  assign gq    = st >= trial;

  assign msq     = (2*MAG_BITS)'(m_q) * (2*MAG_BITS)'(m_q);
  assign std_sat = (sroot_q[25:MAG_BITS] != '0) ? MAG_MAX : sroot_q[MAG_BITS-1:0];

  always_comb begin
    stat_out.result_kind   = 1'b1;
    stat_out.new_mask      = 1'b0;
    stat_out.masked_weight = '0;
    stat_out.mean_abs_out  = m_q;
    stat_out.std_dev_out   = std_sat;
  end

  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (take && head_i.kind == K_FINAL) begin
          state_d = (cnt_q == '0) ? ST_DONE : ST_DIV;
        end
        load_out = take && (head_i.kind == K_CLASS);
      end
      ST_DIV:  if (step_q == 6'(DIV_STEPS - 1)) state_d = ST_MEAN;
      ST_MEAN: state_d = ST_VAR;
      ST_VAR:  state_d = ST_SQRT;
      ST_SQRT: if (step_q == 6'(SQRT_STEPS - 1)) state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_PREP;
        end
      end
      ST_PREP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ratio_q     <= RATIO_RESET;
      abs_q       <= '0;
      sq_q        <= '0;
      cnt_q       <= '0;
      mean_q      <= '0;
      std_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= load_out || (out_valid_q && !out_ready_i);
      if (cfg_we_i) ratio_q <= cfg_data_i;
      if (acc_en) begin
        abs_q <= abs_sum[ABS_W] ? '1 : abs_sum[ABS_W-1:0];
        sq_q  <= (sq_sum > (SQ_W+1)'({SQ_W{1'b1}})) ? '1 : sq_sum[SQ_W-1:0];
        cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == ST_DONE && out_free) begin
        mean_q <= m_q;
        std_q  <= std_sat;
        abs_q  <= '0;
        sq_q   <= '0;
        cnt_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // threshold product follows ratio and latched statistics
    p_q <= PROD_W'(ratio_q) * PROD_W'(mean_q) + PROD_W'(ratio_q) * PROD_W'(std_q);
    if (load_out) out_q <= (state_q == ST_DONE) ? stat_out : cls_out;
    case (state_q)
      ST_IDLE: begin
        qa_q    <= SQ_W'(abs_q);
        qs_q    <= sq_q;
        ra_q    <= '0;
        rs_q    <= '0;
        step_q  <= '0;
        m_q     <= '0;
        srem_q  <= '0;
        sroot_q <= '0;
      end
      ST_DIV: begin
        qa_q   <= {qa_q[SQ_W-2:0], ga};
        qs_q   <= {qs_q[SQ_W-2:0], gs};
        ra_q   <= ga ? CNT_W'(ta - {1'b0, cnt_q}) : ta[CNT_W-1:0];
        rs_q   <= gs ? CNT_W'(ts - {1'b0, cnt_q}) : ts[CNT_W-1:0];
        step_q <= step_q + 1'b1;
      end
      ST_MEAN: begin
        m_q    <= (qa_q[SQ_W-1:MAG_BITS] != '0) ? MAG_MAX : qa_q[MAG_BITS-1:0];
        step_q <= '0;
      end
      ST_VAR: begin
        rad_q <= (qs_q > SQ_W'(msq)) ? (qs_q - SQ_W'(msq)) : '0;
      end
      ST_SQRT: begin
        srem_q  <= gq ? (st - trial) : st;
        sroot_q <= {sroot_q[24:0], gq};
        rad_q   <= {rad_q[SQ_W-3:0], 2'b00};
        step_q  <= step_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/weight_prune_splice_mask.sv */
// ----------------------------------------------------------------------------
// weight_prune_splice_mask
// Pruning and splicing mask unit with running statistics of kept weights.
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_ready_o carries opcode, weight and mask bit.
// Output channel out_valid_o/out_ready_i carries one result for each finalize
// and classify transaction; accumulate and the unused opcode give none.
// cfg_we_i writes the 16-bit threshold ratio (Q4.12).
// Accumulate and classify run one per cycle while the back end is idle and,
// for classify, the result slot is free; a classify result appears on the
// cycle after the item leaves the two-entry queue. Finalize holds the back
// end through the bit-serial divider, the saturation of the mean and the
// variance, the square root, the result load (which waits for a free result
// slot) and the threshold product refresh; with an empty count it goes
// straight to the result load and refresh.
// Following items wait in the queue meanwhile.
// Reset clears the sums, count and statistics and sets the ratio to 1.0.
// When the receiver stalls, the result register holds and the queue fills,
// after which in_ready_o drops.
// ----------------------------------------------------------------------------
`include "weight_prune_splice_mask_defines.svh"

module weight_prune_splice_mask import wps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RATIO_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o
);

  logic   head_valid, pop;
  entry_t head;

  wps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  wps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  `WPS_ASSERT(a_stat_clean, out_valid_o && out_data_o.result_kind |-> !out_data_o.new_mask && out_data_o.masked_weight == '0, "statistics result carries a weight")
  `WPS_ASSERT(a_pruned_zero, out_valid_o && !out_data_o.new_mask |-> out_data_o.masked_weight == '0, "pruned weight not zeroed")
  `WPS_ASSERT(a_pop_needs_head, pop |-> head_valid, "queue popped while empty")
  `WPS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule
